@@ hdl/sitk_pkg.sv @@
package sitk_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int KEY_BYTES   = 8;
   localparam int KEY_W       = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [KEY_W-1:0] KEY_MASK =
      (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DUP     = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [KEY_W-1:0] card_key;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [CNT_W-1:0] position;
      logic [CNT_W-1:0] entries;
   } rsp_type;

endpackage

@@ hdl/sitk_key_ram.sv @@
module sitk_key_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/sorted_id_key_table.sv @@
// Sorted card-key table: holds up to 16 keys of 64 bits in strictly
// descending order and serves insert, delete and lookup requests.
//
// Request channel: a request (cmd, card_key) is taken at a rising edge
// where start is high and busy is low. busy stays high while the request
// is being worked on and drops in the cycle that carries its response.
// Response channel: rsp_strobe is high for exactly one cycle with
// rsp_payload (status, position, entries) valid; the receiver cannot stall,
// so the response must be captured in that cycle.
//
// Each request walks the key memory one entry per cycle through its single
// read port, with the shift of later entries done by the write port in the
// same pass. The strobe is registered from the step at which the walk stops,
// either at index h or at the end of the table.
// A new request can be taken in the strobe cycle.
//
// Reset clears the entry count and all control state; the key memory is
// not cleared, since entries at or above the count are never used.
module sorted_id_key_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sitk_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output sitk_pkg::rsp_type rsp_payload
);

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   typedef enum logic [1:0] {
      M_FIND,
      M_SHIFT_INS,
      M_SHIFT_DEL
   } mode_type;

   localparam int IDX_W = sitk_pkg::IDX_W;
   localparam int CNT_W = sitk_pkg::CNT_W;
   localparam int KEY_W = sitk_pkg::KEY_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(sitk_pkg::TABLE_DEPTH);

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rd_addr_ff, rd_addr_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   d_ff, d_in;
   logic [KEY_W-1:0]   carry_ff, carry_in;
   logic [IDX_W-1:0]   hit_ff, hit_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   sitk_pkg::rsp_type  rsp_ff, rsp_in;

   logic               rd_en;
   logic [KEY_W-1:0]   rd_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [KEY_W-1:0]   wr_data;
   logic               walk_end;
   logic               full;

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   assign full     = (count_ff == FULL_COUNT);
   assign rd_en    = (state_ff == S_WALK) && (rd_addr_ff < count_ff);
   assign walk_end = !rd_vld_ff && (rd_addr_ff == count_ff);

   sitk_key_ram #(
      .DEPTH(sitk_pkg::TABLE_DEPTH),
      .WIDTH(KEY_W)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      rd_addr_in    = rd_addr_ff;
      rd_vld_in     = 1'b0;
      d_in          = d_ff;
      carry_in      = carry_ff;
      hit_in        = hit_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = d_ff;
      wr_data       = carry_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in     = req_payload.cmd;
               key_in     = req_payload.card_key & sitk_pkg::KEY_MASK;
               mode_in    = M_FIND;
               rd_addr_in = '0;
               state_in   = S_WALK;
            end
         end
         S_WALK: begin
            // keep the read stream running one entry ahead of evaluation
            if (rd_en) begin
               rd_vld_in  = 1'b1;
               rd_addr_in = rd_addr_ff + CNT_W'(1);
               d_in       = rd_addr_ff[IDX_W-1:0];
            end

            unique case (mode_ff)
               M_FIND: begin
                  if (rd_vld_ff) begin
                     if (rd_data == key_ff) begin
                        case (cmd_ff)
                           sitk_pkg::CMD_INSERT: begin
                              rsp_in        = '{sitk_pkg::ST_DUP, CNT_W'(d_ff), count_ff};
                              rsp_strobe_in = 1'b1;
                              state_in      = S_IDLE;
                           end
                           sitk_pkg::CMD_DELETE: begin
                              hit_in  = d_ff;
                              mode_in = M_SHIFT_DEL;
                           end
                           default: begin
                              rsp_in        = '{sitk_pkg::ST_OK, CNT_W'(d_ff), count_ff};
                              rsp_strobe_in = 1'b1;
                              state_in      = S_IDLE;
                           end
                        endcase
                     end else if (rd_data < key_ff) begin
                        // first smaller entry: no match can follow
                        if (cmd_ff == sitk_pkg::CMD_INSERT && !full) begin
                           wr_en    = 1'b1;
                           wr_addr  = d_ff;
                           wr_data  = key_ff;
                           carry_in = rd_data;
                           hit_in   = d_ff;
                           mode_in  = M_SHIFT_INS;
                        end else begin
                           rsp_in.status   = (cmd_ff == sitk_pkg::CMD_INSERT) ?
                                             sitk_pkg::ST_FULL : sitk_pkg::ST_MISSING;
                           rsp_in.position = '0;
                           rsp_in.entries  = count_ff;
                           rsp_strobe_in   = 1'b1;
                           state_in        = S_IDLE;
                        end
                     end
                  end else if (walk_end) begin
                     rsp_in.position = '0;
                     rsp_in.status   = sitk_pkg::ST_MISSING;
                     if (cmd_ff == sitk_pkg::CMD_INSERT) begin
                        if (full) begin
                           rsp_in.status = sitk_pkg::ST_FULL;
                        end else begin
                           // append at the tail
                           wr_en           = 1'b1;
                           wr_addr         = count_ff[IDX_W-1:0];
                           wr_data         = key_ff;
                           count_in        = count_ff + CNT_W'(1);
                           rsp_in.status   = sitk_pkg::ST_OK;
                           rsp_in.position = count_ff;
                        end
                     end
                     rsp_in.entries = count_in;
                     rsp_strobe_in  = 1'b1;
                     state_in       = S_IDLE;
                  end
               end
               M_SHIFT_INS: begin
                  if (rd_vld_ff) begin
                     // push the displaced key down one place
                     wr_en    = 1'b1;
                     wr_addr  = d_ff;
                     wr_data  = carry_ff;
                     carry_in = rd_data;
                  end else if (walk_end) begin
                     wr_en         = 1'b1;
                     wr_addr       = count_ff[IDX_W-1:0];
                     wr_data       = carry_ff;
                     count_in      = count_ff + CNT_W'(1);
                     rsp_in        = '{sitk_pkg::ST_OK, CNT_W'(hit_ff), count_in};
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               M_SHIFT_DEL: begin
                  if (rd_vld_ff) begin
                     // close the gap: move each later key up one place
                     wr_en   = 1'b1;
                     wr_addr = d_ff - IDX_W'(1);
                     wr_data = rd_data;
                  end else if (walk_end) begin
                     count_in      = count_ff - CNT_W'(1);
                     rsp_in        = '{sitk_pkg::ST_OK, CNT_W'(hit_ff), count_in};
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= M_FIND;
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rd_addr_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         rd_vld_ff     <= rd_vld_in;
         rd_addr_ff    <= rd_addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff   <= cmd_in;
      key_ff   <= key_in;
      d_ff     <= d_in;
      carry_ff <= carry_in;
      hit_ff   <= hit_in;
      rsp_ff   <= rsp_in;
   end

endmodule
